// ===== hw/rtl/terminal_key_sequence_decoder_core_macros.svh =====
// Assertion macros shared by the terminal key decoder RTL.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_CORE_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TKSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tksd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TKSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tksd: next-cycle check failed");

`endif

// ===== hw/rtl/tksd_pkg.sv =====
// Types, constants and helpers for the terminal key sequence decoder.
`default_nettype none
package tksd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] key_code_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND,
    PH_C,
    PH_D,
    PH_E,
    PH_TILDE
  } phase_t;

  // Key codes
  localparam key_code_t KC_UNREC  = 5'd0;
  localparam key_code_t KC_PLAIN  = 5'd1;
  localparam key_code_t KC_BKSP   = 5'd2;
  localparam key_code_t KC_RET    = 5'd3;
  localparam key_code_t KC_TAB    = 5'd4;
  localparam key_code_t KC_CTRL   = 5'd5;
  localparam key_code_t KC_UP     = 5'd6;
  localparam key_code_t KC_F1     = 5'd10;
  localparam key_code_t KC_F5     = 5'd11;
  localparam key_code_t KC_PGUP   = 5'd12;
  localparam key_code_t KC_PGDN   = 5'd13;
  localparam key_code_t KC_INS    = 5'd14;
  localparam key_code_t KC_DEL    = 5'd15;
  localparam key_code_t KC_CUP    = 5'd16;
  localparam key_code_t KC_ARIGHT = 5'd20;
  localparam key_code_t KC_CARGT  = 5'd22;
  localparam key_code_t KC_SUP    = 5'd24;
  localparam key_code_t KC_MAX    = 5'd27;

  // Byte values
  localparam byte_t BYTE_BS    = 8'd8;
  localparam byte_t BYTE_TAB   = 8'd9;
  localparam byte_t BYTE_LF    = 8'd10;
  localparam byte_t BYTE_ESC   = 8'd27;
  localparam byte_t BYTE_ONE   = 8'd49;
  localparam byte_t BYTE_TWO   = 8'd50;
  localparam byte_t BYTE_THREE = 8'd51;
  localparam byte_t BYTE_FIVE  = 8'd53;
  localparam byte_t BYTE_SIX   = 8'd54;
  localparam byte_t BYTE_SEVEN = 8'd55;
  localparam byte_t BYTE_SEMI  = 8'd59;
  localparam byte_t BYTE_A     = 8'd65;
  localparam byte_t BYTE_D     = 8'd68;
  localparam byte_t BYTE_O     = 8'd79;
  localparam byte_t BYTE_P     = 8'd80;
  localparam byte_t BYTE_TILDE = 8'd126;
  localparam byte_t BYTE_DEL   = 8'd127;

  // Outcome of one byte: next phase, whether a key completes, and stores
  typedef struct packed {
    phase_t    nxt_phase;
    logic      emit;
    key_code_t code;
    logic      wr_first;
    logic      wr_second;
    logic      wr_third;
    logic      wr_fourth;
  } step_t;

  function automatic logic is_control_byte(input byte_t k);
    logic hit;
    unique case (k)
      8'd1, 8'd4, 8'd6, 8'd11, 8'd12, 8'd14, 8'd15, 8'd16,
      8'd18, 8'd19, 8'd20, 8'd21, 8'd24, 8'd31: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_arrow_letter(input byte_t k);
    return (k >= BYTE_A) && (k <= BYTE_D);
  endfunction

  // Offset of an arrow letter from 'A': 0 up, 1 down, 2 right, 3 left
  function automatic logic [1:0] arrow_dir(input byte_t k);
    byte_t diff;
    diff = k - BYTE_A;
    return diff[1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tksd_in_if.sv =====
// Request channel carrying received terminal bytes.
`default_nettype none
interface tksd_in_if import tksd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tksd_out_if.sv =====
// Request channel carrying decoded key codes.
`default_nettype none
interface tksd_out_if import tksd_pkg::*; ();
  logic      valid;
  logic      ready;
  key_code_t key_code;
  byte_t     key_byte;

  modport source (output valid, output key_code, output key_byte, input ready);
  modport sink   (input valid, input key_code, input key_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tksd_decode.sv =====
// Next-phase and key-code logic for one byte of the sequence parser.
`default_nettype none
module tksd_decode import tksd_pkg::*; (
  input  phase_t phase,
  input  byte_t  first_b,
  input  byte_t  second_b,
  input  byte_t  third_b,
  input  byte_t  fourth_b,
  input  byte_t  cur_b,
  output step_t  step
);

  key_code_t mod_code;
  logic [1:0] dir;

  // Modifier arrow: ';' then modifier digit then arrow letter
  always_comb begin
    dir      = arrow_dir(cur_b);
    mod_code = KC_UNREC;
    if (third_b == BYTE_SEMI && is_arrow_letter(cur_b)) begin
      unique case (fourth_b)
        BYTE_FIVE:  mod_code = KC_CUP + key_code_t'(dir);
        BYTE_TWO:   mod_code = KC_SUP + key_code_t'(dir);
        BYTE_THREE: mod_code = dir[1] ? KC_ARIGHT + key_code_t'(dir[0]) : KC_UNREC;
        BYTE_SEVEN: mod_code = dir[1] ? KC_CARGT + key_code_t'(dir[0]) : KC_UNREC;
        default:    mod_code = KC_UNREC;
      endcase
    end
  end

  always_comb begin
    step           = '0;
    step.nxt_phase = PH_IDLE;
    step.code      = KC_UNREC;
    unique case (phase)
      PH_FIRST: begin
        step.wr_first  = 1'b1;
        step.nxt_phase = PH_SECOND;
      end
      PH_SECOND: begin
        step.wr_second = 1'b1;
        priority if (is_arrow_letter(cur_b)) begin
          step.emit = 1'b1;
          step.code = KC_UP + key_code_t'(dir);
        end else if (cur_b == BYTE_ONE) begin
          step.nxt_phase = PH_C;
        end else if (first_b == BYTE_O && cur_b == BYTE_P) begin
          step.emit = 1'b1;
          step.code = KC_F1;
        end else if (first_b == BYTE_O && cur_b == BYTE_FIVE) begin
          step.emit = 1'b1;
          step.code = KC_F5;
        end else if (cur_b == BYTE_FIVE || cur_b == BYTE_SIX ||
                     cur_b == BYTE_TWO || cur_b == BYTE_THREE) begin
          step.nxt_phase = PH_TILDE;
        end else begin
          step.emit = 1'b1;
          step.code = KC_UNREC;
        end
      end
      PH_C: begin
        step.wr_third  = 1'b1;
        step.nxt_phase = PH_D;
      end
      PH_D: begin
        step.wr_fourth = 1'b1;
        if (third_b == BYTE_FIVE && cur_b == BYTE_TILDE) begin
          step.emit = 1'b1;
          step.code = KC_F5;
        end else begin
          step.nxt_phase = PH_E;
        end
      end
      PH_E: begin
        step.emit = 1'b1;
        step.code = mod_code;
      end
      PH_TILDE: begin
        step.wr_third = 1'b1;
        step.emit     = 1'b1;
        if (cur_b != BYTE_TILDE) begin
          step.code = KC_UNREC;
        end else begin
          unique case (second_b)
            BYTE_FIVE: step.code = KC_PGUP;
            BYTE_SIX:  step.code = KC_PGDN;
            BYTE_TWO:  step.code = KC_INS;
            default:   step.code = KC_DEL;
          endcase
        end
      end
      default: begin
        // Idle, and the unused phase code behaves the same
        priority if (cur_b == BYTE_ESC) begin
          step.nxt_phase = PH_FIRST;
        end else if (cur_b == BYTE_DEL || cur_b == BYTE_BS) begin
          step.emit = 1'b1;
          step.code = KC_BKSP;
        end else if (cur_b == BYTE_LF) begin
          step.emit = 1'b1;
          step.code = KC_RET;
        end else if (cur_b == BYTE_TAB) begin
          step.emit = 1'b1;
          step.code = KC_TAB;
        end else if (is_control_byte(cur_b)) begin
          step.emit = 1'b1;
          step.code = KC_CTRL;
        end else begin
          step.emit = 1'b1;
          step.code = KC_PLAIN;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/terminal_key_sequence_decoder_core.sv =====
// Top level: input register, sequence state and result register of the key decoder.
// A byte is held in the input register; a key is written to the result register when its last byte is decoded.
// Throughput: one byte per cycle while results are taken; the single-byte decode
// between the input register and the result register sets that figure.
// Reset: synchronous active-low rst_n clears the phase and both valid flags;
// the stored sequence bytes are not reset and are always written before use.
`default_nettype none
`include "terminal_key_sequence_decoder_core_macros.svh"
module terminal_key_sequence_decoder_core import tksd_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  tksd_in_if.sink    in_chan,
  tksd_out_if.source out_chan
);

  logic      in_v_r;
  byte_t     in_byte_r;
  phase_t    phase_r;
  byte_t     first_r;
  byte_t     second_r;
  byte_t     third_r;
  byte_t     fourth_r;
  logic      out_v_r;
  key_code_t out_code_r;
  byte_t     out_byte_r;

  step_t     dec;
  logic      fire;
  logic      in_take;

  tksd_decode u_decode (
    .phase    (phase_r),
    .first_b  (first_r),
    .second_b (second_r),
    .third_b  (third_r),
    .fourth_b (fourth_r),
    .cur_b    (in_byte_r),
    .step     (dec)
  );

  // Advance the held byte once the result slot is free or being drained
  assign fire    = in_v_r && (!out_v_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;

  assign in_chan.ready     = !in_v_r || fire;
  assign out_chan.valid    = out_v_r;
  assign out_chan.key_code = out_code_r;
  assign out_chan.key_byte = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      phase_r <= PH_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        phase_r <= dec.nxt_phase;
      end
      if (fire && dec.emit) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload and sequence bytes, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_chan.in_byte;
    end
    if (fire) begin
      if (dec.wr_first) begin
        first_r <= in_byte_r;
      end
      if (dec.wr_second) begin
        second_r <= in_byte_r;
      end
      if (dec.wr_third) begin
        third_r <= in_byte_r;
      end
      if (dec.wr_fourth) begin
        fourth_r <= in_byte_r;
      end
      if (dec.emit) begin
        out_code_r <= dec.code;
        out_byte_r <= in_byte_r;
      end
    end
  end

  `TKSD_ASSERT_NEXT(a_emit_returns_idle, fire && dec.emit, out_v_r && phase_r == PH_IDLE)
  `TKSD_ASSERT_NEXT(a_silent_stays_in_seq, fire && !dec.emit, phase_r != PH_IDLE)
  `TKSD_ASSERT_SAME(a_idle_non_esc_emits, fire && phase_r == PH_IDLE && in_byte_r != BYTE_ESC, dec.emit)
  `TKSD_ASSERT_SAME(a_code_in_range, out_v_r, out_code_r <= KC_MAX)
  `TKSD_ASSERT_NEXT(a_held_byte_kept, in_v_r && !fire, in_v_r && $stable(in_byte_r))

endmodule
`default_nettype wire

// ===== verif/tb_terminal_key_sequence_decoder_core.sv =====
// Testbench for the terminal key sequence decoder: table of key sequences, then random bytes.
`timescale 1ns / 1ps
module tb_terminal_key_sequence_decoder_core import tksd_pkg::*; ();

  localparam int unsigned RANDOM_BYTES = 520;
  localparam int unsigned QUIET_TAIL   = 80;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned PAUSE_AT     = 350;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned DIR_ROWS     = 29;
  localparam byte_t       BYTE_LBRACKET = 8'd91;

  typedef struct packed {
    key_code_t code;
    byte_t     kbyte;
  } key_rec_t;

  typedef struct packed {
    byte_t     b;
    logic      typed;
    key_code_t code;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tksd_in_if  in_chan ();
  tksd_out_if out_chan ();

  terminal_key_sequence_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // Decoder state mirrored by the predictor
  phase_t pred_phase = PH_IDLE;
  byte_t  esc_b1 = '0;
  byte_t  esc_b2 = '0;
  byte_t  esc_b3 = '0;
  byte_t  esc_b4 = '0;

  key_rec_t    pending_keys [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  // Directed sequences; the key byte of a typed row is the row's own byte
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00,            1'b1, KC_PLAIN},
    '{8'hFF,            1'b1, KC_PLAIN},
    '{BYTE_DEL,         1'b1, KC_BKSP},
    '{BYTE_BS,          1'b1, KC_BKSP},
    '{8'd31,            1'b1, KC_CTRL},
    // escape taken as data inside a sequence
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_ESC,         1'b1, KC_UNREC},
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_O,           1'b0, KC_UNREC},
    '{BYTE_P,           1'b1, KC_F1},
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_O,           1'b0, KC_UNREC},
    '{BYTE_FIVE,        1'b1, KC_F5},
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_LBRACKET,    1'b0, KC_UNREC},
    '{BYTE_ONE,         1'b0, KC_UNREC},
    '{BYTE_FIVE,        1'b0, KC_UNREC},
    '{BYTE_TILDE,       1'b1, KC_F5},
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_LBRACKET,    1'b0, KC_UNREC},
    '{BYTE_ONE,         1'b0, KC_UNREC},
    '{BYTE_SEMI,        1'b0, KC_UNREC},
    '{BYTE_FIVE,        1'b0, KC_UNREC},
    '{BYTE_A + 8'd2,    1'b0, KC_UNREC},
    '{BYTE_ESC,         1'b0, KC_UNREC},
    '{BYTE_LBRACKET,    1'b0, KC_UNREC},
    '{BYTE_THREE,       1'b0, KC_UNREC},
    '{BYTE_TILDE,       1'b1, KC_DEL}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void decode_byte(input byte_t k, output logic got, output key_code_t code);
    logic [1:0] dir;
    got  = 1'b1;
    code = KC_UNREC;
    dir  = k[1:0] - BYTE_A[1:0];
    case (pred_phase)
      PH_FIRST: begin
        esc_b1     = k;
        pred_phase = PH_SECOND;
        got        = 1'b0;
      end
      PH_SECOND: begin
        esc_b2 = k;
        if (k >= BYTE_A && k <= BYTE_D) begin
          code = KC_UP + key_code_t'(dir);
        end else if (k == BYTE_ONE) begin
          pred_phase = PH_C;
          got        = 1'b0;
        end else if (esc_b1 == BYTE_O && k == BYTE_P) begin
          code = KC_F1;
        end else if (esc_b1 == BYTE_O && k == BYTE_FIVE) begin
          code = KC_F5;
        end else if (k == BYTE_FIVE || k == BYTE_SIX || k == BYTE_TWO || k == BYTE_THREE) begin
          pred_phase = PH_TILDE;
          got        = 1'b0;
        end
      end
      PH_C: begin
        esc_b3     = k;
        pred_phase = PH_D;
        got        = 1'b0;
      end
      PH_D: begin
        esc_b4 = k;
        if (esc_b3 == BYTE_FIVE && k == BYTE_TILDE) begin
          code = KC_F5;
        end else begin
          pred_phase = PH_E;
          got        = 1'b0;
        end
      end
      PH_E: begin
        if (esc_b3 == BYTE_SEMI && k >= BYTE_A && k <= BYTE_D) begin
          case (esc_b4)
            BYTE_FIVE:  code = KC_CUP + key_code_t'(dir);
            BYTE_TWO:   code = KC_SUP + key_code_t'(dir);
            BYTE_THREE: code = dir[1] ? KC_ARIGHT + key_code_t'(dir[0]) : KC_UNREC;
            BYTE_SEVEN: code = dir[1] ? KC_CARGT + key_code_t'(dir[0]) : KC_UNREC;
            default:    code = KC_UNREC;
          endcase
        end
      end
      PH_TILDE: begin
        esc_b3 = k;
        if (k == BYTE_TILDE) begin
          case (esc_b2)
            BYTE_FIVE: code = KC_PGUP;
            BYTE_SIX:  code = KC_PGDN;
            BYTE_TWO:  code = KC_INS;
            default:   code = KC_DEL;
          endcase
        end
      end
      default: begin
        if (k == BYTE_ESC) begin
          pred_phase = PH_FIRST;
          got        = 1'b0;
        end else if (k == BYTE_DEL || k == BYTE_BS) begin
          code = KC_BKSP;
        end else if (k == BYTE_LF) begin
          code = KC_RET;
        end else if (k == BYTE_TAB) begin
          code = KC_TAB;
        end else begin
          case (k)
            8'd1, 8'd4, 8'd6, 8'd11, 8'd12, 8'd14, 8'd15, 8'd16,
            8'd18, 8'd19, 8'd20, 8'd21, 8'd24, 8'd31: code = KC_CTRL;
            default: code = KC_PLAIN;
          endcase
        end
      end
    endcase
    if (got) pred_phase = PH_IDLE;
  endfunction

  // Steer the next byte towards the sequences the decoder is partway through
  function automatic byte_t pick_byte();
    byte_t       anyb;
    int unsigned r;
    anyb = byte_t'($urandom_range(0, 255));
    case (pred_phase)
      PH_FIRST: begin
        r = $urandom_range(0, 3);
        pick_byte = (r < 2) ? BYTE_LBRACKET : (r == 2) ? BYTE_O : anyb;
      end
      PH_SECOND: begin
        case ($urandom_range(0, 9))
          0:       pick_byte = BYTE_A + byte_t'($urandom_range(0, 3));
          1, 2:    pick_byte = BYTE_ONE;
          3:       pick_byte = BYTE_P;
          4:       pick_byte = BYTE_FIVE;
          5:       pick_byte = BYTE_SIX;
          6:       pick_byte = BYTE_TWO;
          7:       pick_byte = BYTE_THREE;
          default: pick_byte = anyb;
        endcase
      end
      PH_C: begin
        r = $urandom_range(0, 3);
        pick_byte = (r == 0) ? BYTE_FIVE : (r < 3) ? BYTE_SEMI : anyb;
      end
      PH_D: begin
        case ($urandom_range(0, 5))
          0:       pick_byte = BYTE_TILDE;
          1:       pick_byte = BYTE_FIVE;
          2:       pick_byte = BYTE_TWO;
          3:       pick_byte = BYTE_THREE;
          4:       pick_byte = BYTE_SEVEN;
          default: pick_byte = anyb;
        endcase
      end
      PH_E: begin
        pick_byte = ($urandom_range(0, 3) < 3) ? BYTE_A + byte_t'($urandom_range(0, 3))
                                                : anyb;
      end
      PH_TILDE: pick_byte = ($urandom_range(0, 3) < 3) ? BYTE_TILDE : anyb;
      default:  pick_byte = ($urandom_range(0, 9) < 3) ? BYTE_ESC : anyb;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Offer one byte, hold it until taken, then predict the key it completes
  task automatic send_byte(input byte_t b, input logic typed, input key_code_t tcode);
    logic      got;
    key_code_t code;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    decode_byte(b, got, code);
    if (typed) pending_keys.push_back(key_rec_t'{tcode, b});
    else if (got) pending_keys.push_back(key_rec_t'{code, b});
  endtask

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].code);
    end
    for (int unsigned i = 0; i < RANDOM_BYTES; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == RANDOM_BYTES - QUIET_TAIL) idle_on = 1'b0;
      if (i == PAUSE_AT) begin
        // drain every outstanding key before offering more
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (pending_keys.size() != 0);
      end
      send_byte(pick_byte(), 1'b0, KC_UNREC);
    end
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_keys.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : key_check
    key_rec_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected key code %0d byte %0d",
                                  out_chan.key_code, out_chan.key_byte));
      end else begin
        want = pending_keys.pop_front();
        if (out_chan.key_code !== want.code)
          report_mismatch($sformatf("key code %0d, predicted %0d (byte %0d)",
                                    out_chan.key_code, want.code, want.kbyte));
        if (out_chan.key_byte !== want.kbyte)
          report_mismatch($sformatf("key byte %0d, predicted %0d",
                                    out_chan.key_byte, want.kbyte));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
